// ===== rtl/core/spring_force_jacobian_block_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the spring stiffness block
// Expect i_clk and i_rst_n in the scope of use.
// ----------------------------------------------------------------------------
`ifndef SPRING_FORCE_JACOBIAN_BLOCK_TOP_ASSERT_SVH
`define SPRING_FORCE_JACOBIAN_BLOCK_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define SFJ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("spring block assertion failed");

// next-cycle implication, off during reset
`define SFJ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("spring block assertion failed");

// condition in the cycle after reset is seen
`define SFJ_ASSERT_RST(lbl, cons) \
    lbl: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) \
        else $error("spring block reset assertion failed");

`endif

// ===== rtl/core/sfj_pkg.sv =====
// ----------------------------------------------------------------------------
// sfj_pkg
// Widths, lane codes and stage payload types of the spring stiffness block.
// ----------------------------------------------------------------------------
package sfj_pkg;

    localparam int COORD_W  = 32;
    localparam int LEN_W    = 31;
    localparam int K_W      = 16;
    localparam int ENT_W    = 32;
    localparam int MAG_W    = 32;
    localparam int SQR_W    = 2 * MAG_W;
    localparam int S_W      = SQR_W + 2;
    localparam int SQ_STEPS = 34;
    localparam int D_W      = SQ_STEPS;
    localparam int KL_W     = K_W + LEN_W;
    localparam int DIV_W    = 63;
    localparam int DV_LANES = 4;
    localparam int U_SH     = 30;
    localparam int K_SH     = 16;
    localparam int U_W      = U_SH + 1;
    localparam int C_W      = DIV_W;
    localparam int X_W      = 2 * U_SH + 1;
    localparam int FRAC_SH  = 2 * U_SH;
    localparam int M_W      = 63;
    localparam int LANES    = 6;

    localparam int LN_XX = 0;
    localparam int LN_XY = 1;
    localparam int LN_XZ = 2;
    localparam int LN_YY = 3;
    localparam int LN_YZ = 4;
    localparam int LN_ZZ = 5;
    localparam int DV_C  = 3;

    localparam logic [LANES-1:0] LANE_DIAG = (LANES'(1) << LN_XX) | (LANES'(1) << LN_YY)
                                           | (LANES'(1) << LN_ZZ);

    localparam logic [X_W-1:0]   X_ONE   = {1'b1, {(X_W-1){1'b0}}};
    localparam logic [ENT_W-1:0] ENT_MAX = {1'b0, {(ENT_W-1){1'b1}}};
    localparam logic [ENT_W-1:0] ENT_MIN = {1'b1, {(ENT_W-1){1'b0}}};

    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
        logic [KL_W-1:0]       kl;
        logic                  deg;
    } t_sq_tag;

    typedef struct packed {
        logic [2:0] neg;
        logic       deg;
    } t_dv_tag;

    typedef struct packed {
        logic [LANES-1:0] neg;
        logic             deg;
    } t_mu_tag;

    typedef struct packed {
        logic [LANES-1:0][ENT_W-1:0] ent;
        logic                        deg;
    } t_res;

endpackage

// ===== rtl/core/sfj_if.sv =====
// ----------------------------------------------------------------------------
// sfj_if
// Channel interfaces: spring input, stiffness block result, stiffness write.
// ----------------------------------------------------------------------------
interface sfj_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [sfj_pkg::COORD_W-1:0]    end_a_x;
    logic signed [sfj_pkg::COORD_W-1:0]    end_a_y;
    logic signed [sfj_pkg::COORD_W-1:0]    end_a_z;
    logic signed [sfj_pkg::COORD_W-1:0]    end_b_x;
    logic signed [sfj_pkg::COORD_W-1:0]    end_b_y;
    logic signed [sfj_pkg::COORD_W-1:0]    end_b_z;
    logic        [sfj_pkg::LEN_W-1:0]      rest_length;

    modport source (output valid, end_a_x, end_a_y, end_a_z, end_b_x, end_b_y, end_b_z,
                    rest_length, input ready);
    modport sink (input valid, end_a_x, end_a_y, end_a_z, end_b_x, end_b_y, end_b_z,
                  rest_length, output ready);
endinterface

interface sfj_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [sfj_pkg::ENT_W-1:0]   block_xx;
    logic signed [sfj_pkg::ENT_W-1:0]   block_xy;
    logic signed [sfj_pkg::ENT_W-1:0]   block_xz;
    logic signed [sfj_pkg::ENT_W-1:0]   block_yy;
    logic signed [sfj_pkg::ENT_W-1:0]   block_yz;
    logic signed [sfj_pkg::ENT_W-1:0]   block_zz;
    logic                               degenerate;

    modport source (output valid, block_xx, block_xy, block_xz, block_yy, block_yz,
                    block_zz, degenerate, input ready);
    modport sink (input valid, block_xx, block_xy, block_xz, block_yy, block_yz,
                  block_zz, degenerate, output ready);
endinterface

interface sfj_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [sfj_pkg::K_W-1:0]     spring_stiffness;

    modport source (output valid, spring_stiffness, input ready);
    modport sink (input valid, spring_stiffness, output ready);
endinterface

// ===== rtl/core/sfj_sqrt.sv =====
// ----------------------------------------------------------------------------
// sfj_sqrt
// Pipelined integer square root, one root bit per stage, tag carried along.
// ----------------------------------------------------------------------------
module sfj_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [sfj_pkg::S_W-1:0]    i_rad,
    input  sfj_pkg::t_sq_tag           i_tag,
    output logic                       o_valid,
    output logic [sfj_pkg::D_W-1:0]    o_root,
    output sfj_pkg::t_sq_tag           o_tag
);

    localparam int N  = sfj_pkg::SQ_STEPS;
    localparam int RW = sfj_pkg::D_W + 1;
    localparam int PW = 2 * N;

    logic [N-1:0]              r_v;
    logic [RW-1:0]             r_rem  [N];
    logic [sfj_pkg::D_W-1:0]   r_root [N];
    logic [PW-1:0]             r_rad  [N];
    sfj_pkg::t_sq_tag          r_tag  [N];

    logic [RW-1:0]             n_rem  [N];
    logic [sfj_pkg::D_W-1:0]   n_root [N];
    logic [PW-1:0]             n_rad  [N];
    sfj_pkg::t_sq_tag          n_tag  [N];

    logic [RW-1:0]             w_rem  [N+1];
    logic [sfj_pkg::D_W-1:0]   w_root [N+1];
    logic [PW-1:0]             w_rad  [N+1];
    sfj_pkg::t_sq_tag          w_tag  [N+1];

    always_comb begin
        logic [RW+1:0] acc;
        logic [RW+1:0] trial;
        w_rem[0]  = '0;
        w_root[0] = '0;
        w_rad[0]  = PW'(i_rad);
        w_tag[0]  = i_tag;
        for (int k = 0; k < N; k++) begin
            w_rem[k+1]  = r_rem[k];
            w_root[k+1] = r_root[k];
            w_rad[k+1]  = r_rad[k];
            w_tag[k+1]  = r_tag[k];
        end
        for (int k = 0; k < N; k++) begin
            acc   = {w_rem[k], w_rad[k][PW-1 -: 2]};
            trial = {1'b0, w_root[k], 2'b01};
            if (acc >= trial) begin
                n_rem[k]  = RW'(acc - trial);
                n_root[k] = {w_root[k][sfj_pkg::D_W-2:0], 1'b1};
            end else begin
                n_rem[k]  = acc[RW-1:0];
                n_root[k] = {w_root[k][sfj_pkg::D_W-2:0], 1'b0};
            end
            n_rad[k] = {w_rad[k][PW-3:0], 2'b00};
            n_tag[k] = w_tag[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[N-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_rad  <= n_rad;
            r_tag  <= n_tag;
        end
    end

    assign o_valid = r_v[N-1];
    assign o_root  = r_root[N-1];
    assign o_tag   = r_tag[N-1];

endmodule

// ===== rtl/core/sfj_div.sv =====
// ----------------------------------------------------------------------------
// sfj_div
// Pipelined restoring divider, four lanes over one shared divisor.
// ----------------------------------------------------------------------------
module sfj_div (
    input  logic                                                 i_clk,
    input  logic                                                 i_rst_n,
    input  logic                                                 i_en,
    input  logic                                                 i_valid,
    input  logic [sfj_pkg::D_W-1:0]                              i_divisor,
    input  logic [sfj_pkg::DV_LANES-1:0][sfj_pkg::DIV_W-1:0]     i_num,
    input  sfj_pkg::t_dv_tag                                     i_tag,
    output logic                                                 o_valid,
    output logic [sfj_pkg::DV_LANES-1:0][sfj_pkg::DIV_W-1:0]     o_quot,
    output sfj_pkg::t_dv_tag                                     o_tag
);

    localparam int N  = sfj_pkg::DIV_W;
    localparam int L  = sfj_pkg::DV_LANES;
    localparam int DW = sfj_pkg::D_W;

    logic [N-1:0]             r_v;
    logic [L-1:0][DW-1:0]     r_rem [N];
    logic [L-1:0][N-1:0]      r_num [N];
    logic [DW-1:0]            r_dvs [N];
    sfj_pkg::t_dv_tag         r_tag [N];

    logic [L-1:0][DW-1:0]     n_rem [N];
    logic [L-1:0][N-1:0]      n_num [N];
    logic [DW-1:0]            n_dvs [N];
    sfj_pkg::t_dv_tag         n_tag [N];

    logic [L-1:0][DW-1:0]     w_rem [N+1];
    logic [L-1:0][N-1:0]      w_num [N+1];
    logic [DW-1:0]            w_dvs [N+1];
    sfj_pkg::t_dv_tag         w_tag [N+1];

    always_comb begin
        logic [DW:0] acc;
        w_rem[0] = '0;
        w_num[0] = i_num;
        w_dvs[0] = i_divisor;
        w_tag[0] = i_tag;
        for (int k = 0; k < N; k++) begin
            w_rem[k+1] = r_rem[k];
            w_num[k+1] = r_num[k];
            w_dvs[k+1] = r_dvs[k];
            w_tag[k+1] = r_tag[k];
        end
        for (int k = 0; k < N; k++) begin
            for (int l = 0; l < L; l++) begin
                acc = {w_rem[k][l], w_num[k][l][N-1]};
                if (acc >= {1'b0, w_dvs[k]}) begin
                    n_rem[k][l] = DW'(acc - {1'b0, w_dvs[k]});
                    n_num[k][l] = {w_num[k][l][N-2:0], 1'b1};
                end else begin
                    n_rem[k][l] = acc[DW-1:0];
                    n_num[k][l] = {w_num[k][l][N-2:0], 1'b0};
                end
            end
            n_dvs[k] = w_dvs[k];
            n_tag[k] = w_tag[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[N-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_num <= n_num;
            r_dvs <= n_dvs;
            r_tag <= n_tag;
        end
    end

    assign o_valid = r_v[N-1];
    assign o_quot  = r_num[N-1];
    assign o_tag   = r_tag[N-1];

endmodule

// ===== rtl/core/sfj_mulsh.sv =====
// ----------------------------------------------------------------------------
// sfj_mulsh
// Six-lane wide product shifted down by the fraction width, three stages:
// partial products, middle sum, final sum.
// ----------------------------------------------------------------------------
module sfj_mulsh (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_en,
    input  logic                                             i_valid,
    input  logic [sfj_pkg::C_W-1:0]                          i_c,
    input  logic [sfj_pkg::LANES-1:0][sfj_pkg::X_W-1:0]      i_x,
    input  sfj_pkg::t_mu_tag                                 i_tag,
    output logic                                             o_valid,
    output logic [sfj_pkg::LANES-1:0][sfj_pkg::M_W-1:0]      o_m,
    output sfj_pkg::t_mu_tag                                 o_tag
);

    localparam int L      = sfj_pkg::LANES;
    localparam int CL     = 32;
    localparam int CH     = sfj_pkg::C_W - CL;
    localparam int XL     = 32;
    localparam int XH     = sfj_pkg::X_W - XL;
    localparam int LL_W   = CL + XL;
    localparam int LH_W   = CL + XH;
    localparam int HL_W   = CH + XL;
    localparam int HH_W   = CH + XH;
    localparam int MID_W  = ((LH_W > HL_W) ? LH_W : HL_W) + 1;
    localparam int FULL_W = sfj_pkg::C_W + sfj_pkg::X_W;

    logic [2:0]               r_v;
    sfj_pkg::t_mu_tag         r_tag [3];

    logic [L-1:0][LL_W-1:0]   r_a_ll, n_a_ll;
    logic [L-1:0][LH_W-1:0]   r_a_lh, n_a_lh;
    logic [L-1:0][HL_W-1:0]   r_a_hl, n_a_hl;
    logic [L-1:0][HH_W-1:0]   r_a_hh, n_a_hh;
    logic [L-1:0][LL_W-1:0]   r_b_ll;
    logic [L-1:0][MID_W-1:0]  r_b_mid, n_b_mid;
    logic [L-1:0][HH_W-1:0]   r_b_hh;
    logic [L-1:0][sfj_pkg::M_W-1:0] r_c_m, n_c_m;

    always_comb begin
        logic [FULL_W-1:0] full;
        for (int l = 0; l < L; l++) begin
            n_a_ll[l]  = i_c[CL-1:0] * i_x[l][XL-1:0];
            n_a_lh[l]  = i_c[CL-1:0] * i_x[l][sfj_pkg::X_W-1:XL];
            n_a_hl[l]  = i_c[sfj_pkg::C_W-1:CL] * i_x[l][XL-1:0];
            n_a_hh[l]  = i_c[sfj_pkg::C_W-1:CL] * i_x[l][sfj_pkg::X_W-1:XL];
            n_b_mid[l] = MID_W'(r_a_lh[l]) + MID_W'(r_a_hl[l]);
            full       = (FULL_W'(r_b_hh[l]) << (CL + XL)) + (FULL_W'(r_b_mid[l]) << CL)
                       + FULL_W'(r_b_ll[l]);
            n_c_m[l]   = full[sfj_pkg::FRAC_SH +: sfj_pkg::M_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_ll  <= n_a_ll;
            r_a_lh  <= n_a_lh;
            r_a_hl  <= n_a_hl;
            r_a_hh  <= n_a_hh;
            r_b_ll  <= r_a_ll;
            r_b_mid <= n_b_mid;
            r_b_hh  <= r_a_hh;
            r_c_m   <= n_c_m;
            r_tag[0] <= i_tag;
            r_tag[1] <= r_tag[0];
            r_tag[2] <= r_tag[1];
        end
    end

    assign o_valid = r_v[2];
    assign o_m     = r_c_m;
    assign o_tag   = r_tag[2];

endmodule

// ===== rtl/core/spring_force_jacobian_block_top.sv =====
// ----------------------------------------------------------------------------
// spring_force_jacobian_block_top
// A result passes the input registers, 34 square-root stages, 63 divider
// stages, the scaling registers, the multiplier and the output register.
// Throughput: one spring per cycle; the whole pipeline holds while the skid
// register is full. Reset clears all valid bits and the stiffness to zero.
// ----------------------------------------------------------------------------
module spring_force_jacobian_block_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sfj_cfg_if.sink     i_cfg,
    sfj_in_if.sink      i_in,
    sfj_out_if.source   o_out
);

    localparam int L    = sfj_pkg::LANES;
    localparam int DG_W = sfj_pkg::M_W + 2;

    logic                          en;
    logic [sfj_pkg::K_W-1:0]       r_k;

    logic                          r_s0_v;
    logic [2:0][sfj_pkg::MAG_W-1:0] r_s0_mag, n_s0_mag;
    logic [2:0]                    r_s0_neg, n_s0_neg;
    logic [sfj_pkg::LEN_W-1:0]     r_s0_len;

    logic                          r_s1_v;
    logic [2:0][sfj_pkg::SQR_W-1:0] r_s1_sq;
    logic [2:0][sfj_pkg::MAG_W-1:0] r_s1_mag;
    logic [2:0]                    r_s1_neg;
    logic [sfj_pkg::KL_W-1:0]      r_s1_kl;
    logic                          r_s1_deg;

    logic                          r_s2_v;
    logic [sfj_pkg::S_W-1:0]       r_s2_s;
    sfj_pkg::t_sq_tag              r_s2_tag;

    logic                          sq_v;
    logic [sfj_pkg::D_W-1:0]       sq_root;
    sfj_pkg::t_sq_tag              sq_tag;

    logic [sfj_pkg::DV_LANES-1:0][sfj_pkg::DIV_W-1:0] dv_num;
    sfj_pkg::t_dv_tag              dv_tag_in;
    logic                          dv_v;
    logic [sfj_pkg::DV_LANES-1:0][sfj_pkg::DIV_W-1:0] dv_quot;
    sfj_pkg::t_dv_tag              dv_tag;

    logic                          r_s3_v;
    logic [L-1:0][sfj_pkg::X_W-1:0] r_s3_p, n_s3_p;
    logic [sfj_pkg::C_W-1:0]       r_s3_c;
    sfj_pkg::t_mu_tag              r_s3_tag, n_s3_tag;

    logic                          r_s4_v;
    logic [L-1:0][sfj_pkg::X_W-1:0] r_s4_x, n_s4_x;
    logic [sfj_pkg::C_W-1:0]       r_s4_c;
    sfj_pkg::t_mu_tag              r_s4_tag;

    logic                          mu_v;
    logic [L-1:0][sfj_pkg::M_W-1:0] mu_m;
    sfj_pkg::t_mu_tag              mu_tag;

    sfj_pkg::t_res                 n_res, r_out, r_skid;
    logic                          r_out_v, n_out_v, r_skid_v, n_skid_v;
    logic                          load_out, load_skid, from_skid;

    assign en          = !r_skid_v;
    assign i_in.ready  = en;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
        end else if (i_cfg.valid) begin
            r_k <= i_cfg.spring_stiffness;
        end
    end

    always_comb begin
        logic [sfj_pkg::COORD_W:0] diff [3];
        diff[0] = {i_in.end_a_x[sfj_pkg::COORD_W-1], i_in.end_a_x}
                - {i_in.end_b_x[sfj_pkg::COORD_W-1], i_in.end_b_x};
        diff[1] = {i_in.end_a_y[sfj_pkg::COORD_W-1], i_in.end_a_y}
                - {i_in.end_b_y[sfj_pkg::COORD_W-1], i_in.end_b_y};
        diff[2] = {i_in.end_a_z[sfj_pkg::COORD_W-1], i_in.end_a_z}
                - {i_in.end_b_z[sfj_pkg::COORD_W-1], i_in.end_b_z};
        for (int i = 0; i < 3; i++) begin
            n_s0_neg[i] = diff[i][sfj_pkg::COORD_W];
            n_s0_mag[i] = diff[i][sfj_pkg::COORD_W] ?
                          sfj_pkg::MAG_W'((sfj_pkg::COORD_W+1)'(0) - diff[i]) :
                          diff[i][sfj_pkg::MAG_W-1:0];
        end
    end

    assign dv_tag_in.neg = sq_tag.neg;
    assign dv_tag_in.deg = sq_tag.deg;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dv_num[i] = {1'b0, sq_tag.mag[i], {sfj_pkg::U_SH{1'b0}}};
        end
        dv_num[sfj_pkg::DV_C] = {sq_tag.kl, {sfj_pkg::K_SH{1'b0}}};
    end

    always_comb begin
        logic [2*sfj_pkg::U_W-1:0] prod [L];
        logic [sfj_pkg::U_W-1:0]   u    [3];
        for (int i = 0; i < 3; i++) begin
            u[i] = dv_quot[i][sfj_pkg::U_W-1:0];
        end
        prod[sfj_pkg::LN_XX] = u[0] * u[0];
        prod[sfj_pkg::LN_XY] = u[0] * u[1];
        prod[sfj_pkg::LN_XZ] = u[0] * u[2];
        prod[sfj_pkg::LN_YY] = u[1] * u[1];
        prod[sfj_pkg::LN_YZ] = u[1] * u[2];
        prod[sfj_pkg::LN_ZZ] = u[2] * u[2];
        for (int l = 0; l < L; l++) begin
            n_s3_p[l] = prod[l][sfj_pkg::X_W-1:0];
        end
        n_s3_tag.neg                  = '0;
        n_s3_tag.neg[sfj_pkg::LN_XY]  = dv_tag.neg[0] ^ dv_tag.neg[1];
        n_s3_tag.neg[sfj_pkg::LN_XZ]  = dv_tag.neg[0] ^ dv_tag.neg[2];
        n_s3_tag.neg[sfj_pkg::LN_YZ]  = dv_tag.neg[1] ^ dv_tag.neg[2];
        n_s3_tag.deg                  = dv_tag.deg;
    end

    always_comb begin
        for (int l = 0; l < L; l++) begin
            n_s4_x[l] = sfj_pkg::LANE_DIAG[l] ? (sfj_pkg::X_ONE - r_s3_p[l]) : r_s3_p[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else if (en) begin
            r_s0_v <= i_in.valid;
            r_s1_v <= r_s0_v;
            r_s2_v <= r_s1_v;
            r_s3_v <= dv_v;
            r_s4_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_mag <= n_s0_mag;
            r_s0_neg <= n_s0_neg;
            r_s0_len <= i_in.rest_length;
            for (int i = 0; i < 3; i++) begin
                r_s1_sq[i] <= r_s0_mag[i] * r_s0_mag[i];
            end
            r_s1_mag <= r_s0_mag;
            r_s1_neg <= r_s0_neg;
            r_s1_kl  <= r_k * r_s0_len;
            r_s1_deg <= (r_s0_mag == '0);
            r_s2_s   <= sfj_pkg::S_W'(r_s1_sq[0]) + sfj_pkg::S_W'(r_s1_sq[1])
                      + sfj_pkg::S_W'(r_s1_sq[2]);
            r_s2_tag.mag <= r_s1_mag;
            r_s2_tag.neg <= r_s1_neg;
            r_s2_tag.kl  <= r_s1_kl;
            r_s2_tag.deg <= r_s1_deg;
            r_s3_p   <= n_s3_p;
            r_s3_c   <= dv_quot[sfj_pkg::DV_C];
            r_s3_tag <= n_s3_tag;
            r_s4_x   <= n_s4_x;
            r_s4_c   <= r_s3_c;
            r_s4_tag <= r_s3_tag;
        end
    end

    sfj_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s2_v),
        .i_rad   (r_s2_s),
        .i_tag   (r_s2_tag),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_tag   (sq_tag)
    );

    sfj_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (sq_v),
        .i_divisor (sq_root),
        .i_num     (dv_num),
        .i_tag     (dv_tag_in),
        .o_valid   (dv_v),
        .o_quot    (dv_quot),
        .o_tag     (dv_tag)
    );

    sfj_mulsh u_mulsh (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s4_v),
        .i_c     (r_s4_c),
        .i_x     (r_s4_x),
        .i_tag   (r_s4_tag),
        .o_valid (mu_v),
        .o_m     (mu_m),
        .o_tag   (mu_tag)
    );

    always_comb begin
        logic [DG_W-1:0]         dv;
        logic [sfj_pkg::M_W-1:0] m;
        n_res.deg = mu_tag.deg;
        for (int l = 0; l < L; l++) begin
            m  = mu_m[l];
            dv = {{(DG_W-sfj_pkg::K_W-sfj_pkg::K_SH){1'b0}}, r_k, {sfj_pkg::K_SH{1'b0}}}
               - {2'b00, m};
            if (sfj_pkg::LANE_DIAG[l]) begin
                if (!dv[DG_W-1] && (|dv[DG_W-2:sfj_pkg::ENT_W-1])) begin
                    n_res.ent[l] = sfj_pkg::ENT_MAX;
                end else if (dv[DG_W-1] && !(&dv[DG_W-2:sfj_pkg::ENT_W-1])) begin
                    n_res.ent[l] = sfj_pkg::ENT_MIN;
                end else begin
                    n_res.ent[l] = dv[sfj_pkg::ENT_W-1:0];
                end
            end else if (mu_tag.neg[l]) begin
                n_res.ent[l] = (|m[sfj_pkg::M_W-1:sfj_pkg::ENT_W-1]) ? sfj_pkg::ENT_MIN :
                               sfj_pkg::ENT_W'(0) - m[sfj_pkg::ENT_W-1:0];
            end else begin
                n_res.ent[l] = (|m[sfj_pkg::M_W-1:sfj_pkg::ENT_W-1]) ? sfj_pkg::ENT_MAX :
                               m[sfj_pkg::ENT_W-1:0];
            end
            if (mu_tag.deg) begin
                n_res.ent[l] = '0;
            end
        end
    end

    always_comb begin
        n_out_v   = r_out_v;
        n_skid_v  = r_skid_v;
        load_out  = 1'b0;
        load_skid = 1'b0;
        from_skid = 1'b0;
        if (r_skid_v) begin
            if (!r_out_v || o_out.ready) begin
                load_out  = 1'b1;
                from_skid = 1'b1;
                n_out_v   = 1'b1;
                n_skid_v  = 1'b0;
            end
        end else if (mu_v) begin
            if (!r_out_v || o_out.ready) begin
                load_out = 1'b1;
                n_out_v  = 1'b1;
            end else begin
                load_skid = 1'b1;
                n_skid_v  = 1'b1;
            end
        end else if (o_out.ready) begin
            n_out_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= from_skid ? r_skid : n_res;
        end
        if (load_skid) begin
            r_skid <= n_res;
        end
    end

    assign o_out.valid      = r_out_v;
    assign o_out.block_xx   = r_out.ent[sfj_pkg::LN_XX];
    assign o_out.block_xy   = r_out.ent[sfj_pkg::LN_XY];
    assign o_out.block_xz   = r_out.ent[sfj_pkg::LN_XZ];
    assign o_out.block_yy   = r_out.ent[sfj_pkg::LN_YY];
    assign o_out.block_yz   = r_out.ent[sfj_pkg::LN_YZ];
    assign o_out.block_zz   = r_out.ent[sfj_pkg::LN_ZZ];
    assign o_out.degenerate = r_out.deg;

`include "spring_force_jacobian_block_top_assert.svh"

    `SFJ_ASSERT_IMP(a_skid_needs_out, r_skid_v, r_out_v)
    `SFJ_ASSERT_IMP(a_deg_zero, r_out_v && r_out.deg, r_out.ent == '0)
    `SFJ_ASSERT_NXT(a_skid_on_stall, !r_skid_v && mu_v && r_out_v && !o_out.ready, r_skid_v)
    `SFJ_ASSERT_RST(a_reset_empty, !r_out_v && !r_skid_v)

endmodule
